// ===== rtl/core/utf8_to_numeric_char_ref_defines.svh =====
// ----------------------------------------------------------------------------
// utf8_to_numeric_char_ref_defines
// assertion macros used by the back end of the utf8 to numeric reference converter
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_NUMERIC_CHAR_REF_DEFINES_SVH
`define UTF8_TO_NUMERIC_CHAR_REF_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off while rst_ni is low
`define U2NCR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on clk_i, off while rst_ni is low
`define U2NCR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/u2ncr_pkg.sv =====
// ----------------------------------------------------------------------------
// u2ncr_pkg
// types, constants and decode helpers of the utf8 to numeric reference block
// ----------------------------------------------------------------------------
package u2ncr_pkg;

  // default cap on output bytes of one text
  localparam int OUT_LIMIT_DEFAULT = 256;

  // code point and digit sizes
  localparam int CODE_W     = 21;
  localparam int MAX_DIGITS = 7;
  localparam int ND_W       = 3;
  localparam int REF_EXTRA  = 3;

  // command queue between the two halves
  localparam int CQ_DEPTH = 4;
  localparam int CQ_PTR_W = 2;

  // reference characters
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_ZERO = 8'h30;

  // multiply-by-reciprocal divide by ten, exact below 2^21
  localparam logic [19:0] RECIP10   = 20'hccccd;
  localparam int          RECIP_SHR = 23;

  typedef enum logic [1:0] {
    CMD_RAW,
    CMD_REF,
    CMD_TERM
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [CODE_W-1:0]  data;
    logic               item_end;
  } cmd_t;

  typedef enum logic [2:0] {
    FR_ACCEPT,
    FR_TLEAD,
    FR_TB1,
    FR_TB2,
    FR_TERM
  } front_state_e;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_CONV,
    BK_CHECK,
    BK_AMP,
    BK_HASH,
    BK_DIG,
    BK_SEMI
  } back_state_e;

  // number of continuation bytes a lead byte asks for
  function automatic logic [1:0] need_of(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if ((b & 8'hf8) == 8'hf0) begin
      n = 2'd3;
    end else if ((b & 8'hf0) == 8'he0) begin
      n = 2'd2;
    end else if ((b & 8'he0) == 8'hc0) begin
      n = 2'd1;
    end
    return n;
  endfunction

  // code point from a lead, two held bytes and the closing byte
  function automatic logic [CODE_W-1:0] code_of(input logic [7:0] lead,
                                                 input logic [7:0] h0,
                                                 input logic [7:0] h1,
                                                 input logic [7:0] b,
                                                 input logic [1:0] k);
    logic [CODE_W-1:0] c;
    case (k)
      2'd3:    c = {lead[2:0], h0[5:0], h1[5:0], b[5:0]};
      2'd2:    c = {5'd0, lead[3:0], h0[5:0], b[5:0]};
      default: c = {10'd0, lead[4:0], b[5:0]};
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/u2ncr_front.sv =====
// ----------------------------------------------------------------------------
// u2ncr_front
// accepts input bytes, tracks pending sequences and issues commands
// ----------------------------------------------------------------------------
module u2ncr_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              text_last_i,
  output logic              push_o,
  output u2ncr_pkg::cmd_t   push_cmd_o,
  input  logic              q_full_i
);

  u2ncr_pkg::front_state_e state_q, state_d;
  logic [7:0] lead_q, lead_d;
  logic [7:0] h0_q, h0_d, h1_q, h1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pend_q, pend_d;
  logic       accept;
  logic [1:0] need_l;
  logic [1:0] need_b;
  logic       seq_done;

  assign in_ready_o = (state_q == u2ncr_pkg::FR_ACCEPT) && !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign need_l     = u2ncr_pkg::need_of(lead_q);
  assign need_b     = u2ncr_pkg::need_of(in_byte_i);
  assign seq_done   = ({1'b0, cnt_q} + 3'd1) >= {1'b0, need_l};

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      u2ncr_pkg::FR_ACCEPT: begin
        if (accept && text_last_i) begin
          if (pend_d) begin
            state_d = u2ncr_pkg::FR_TLEAD;
          end else begin
            state_d = u2ncr_pkg::FR_TERM;
          end
        end
      end
      u2ncr_pkg::FR_TLEAD: begin
        if (!q_full_i) begin
          state_d = (cnt_q == 2'd0) ? u2ncr_pkg::FR_TERM : u2ncr_pkg::FR_TB1;
        end
      end
      u2ncr_pkg::FR_TB1: begin
        if (!q_full_i) begin
          if (cnt_q == 2'd2 && u2ncr_pkg::need_of(h0_q) != 2'd1) begin
            state_d = u2ncr_pkg::FR_TB2;
          end else begin
            state_d = u2ncr_pkg::FR_TERM;
          end
        end
      end
      u2ncr_pkg::FR_TB2: begin
        if (!q_full_i) begin
          state_d = u2ncr_pkg::FR_TERM;
        end
      end
      u2ncr_pkg::FR_TERM: begin
        if (!q_full_i) begin
          state_d = u2ncr_pkg::FR_ACCEPT;
        end
      end
      default: state_d = u2ncr_pkg::FR_ACCEPT;
    endcase
  end

  // command issue and sequence tracking
  always_comb begin
    push_o     = 1'b0;
    push_cmd_o = '{kind: u2ncr_pkg::CMD_RAW, data: '0, item_end: 1'b0};
    lead_d     = lead_q;
    h0_d       = h0_q;
    h1_d       = h1_q;
    cnt_d      = cnt_q;
    pend_d     = pend_q;
    case (state_q)
      u2ncr_pkg::FR_ACCEPT: begin
        if (accept) begin
          push_cmd_o.item_end = !text_last_i;
          if (pend_q) begin
            if (seq_done) begin
              push_o          = 1'b1;
              push_cmd_o.kind = u2ncr_pkg::CMD_REF;
              push_cmd_o.data = u2ncr_pkg::code_of(lead_q, h0_q, h1_q, in_byte_i, need_l);
              pend_d          = 1'b0;
              cnt_d           = 2'd0;
            end else begin
              // at most two bytes wait here, the third one closes the sequence
              if (cnt_q[0]) begin
                h1_d = in_byte_i;
              end else begin
                h0_d = in_byte_i;
              end
              cnt_d = cnt_q + 2'd1;
            end
          end else if (need_b != 2'd0) begin
            lead_d = in_byte_i;
            pend_d = 1'b1;
            cnt_d  = 2'd0;
          end else begin
            push_o          = 1'b1;
            push_cmd_o.kind = u2ncr_pkg::CMD_RAW;
            push_cmd_o.data = {{(u2ncr_pkg::CODE_W-8){1'b0}}, in_byte_i};
          end
        end
      end
      // text ended inside a sequence: lead goes out raw
      u2ncr_pkg::FR_TLEAD: begin
        push_o          = !q_full_i;
        push_cmd_o.kind = u2ncr_pkg::CMD_RAW;
        push_cmd_o.data = {{(u2ncr_pkg::CODE_W-8){1'b0}}, lead_q};
      end
      // first held byte may itself open a two-byte sequence
      u2ncr_pkg::FR_TB1: begin
        push_o = !q_full_i;
        if (cnt_q == 2'd2 && u2ncr_pkg::need_of(h0_q) == 2'd1) begin
          push_cmd_o.kind = u2ncr_pkg::CMD_REF;
          push_cmd_o.data = u2ncr_pkg::code_of(h0_q, h0_q, h0_q, h1_q, 2'd1);
        end else begin
          push_cmd_o.kind = u2ncr_pkg::CMD_RAW;
          push_cmd_o.data = {{(u2ncr_pkg::CODE_W-8){1'b0}}, h0_q};
        end
      end
      u2ncr_pkg::FR_TB2: begin
        push_o          = !q_full_i;
        push_cmd_o.kind = u2ncr_pkg::CMD_RAW;
        push_cmd_o.data = {{(u2ncr_pkg::CODE_W-8){1'b0}}, h1_q};
      end
      u2ncr_pkg::FR_TERM: begin
        push_o              = !q_full_i;
        push_cmd_o.kind     = u2ncr_pkg::CMD_TERM;
        push_cmd_o.item_end = 1'b1;
        if (!q_full_i) begin
          pend_d = 1'b0;
          cnt_d  = 2'd0;
          lead_d = 8'd0;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= u2ncr_pkg::FR_ACCEPT;
      lead_q  <= 8'd0;
      cnt_q   <= 2'd0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      lead_q  <= lead_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
    end
  end

  // held continuation bytes
  always_ff @(posedge clk_i) begin
    h0_q <= h0_d;
    h1_q <= h1_d;
  end

endmodule

// ===== rtl/core/u2ncr_cmdq.sv =====
// ----------------------------------------------------------------------------
// u2ncr_cmdq
// small command queue between the byte front end and the output back end
// ----------------------------------------------------------------------------
module u2ncr_cmdq (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u2ncr_pkg::cmd_t   push_cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output u2ncr_pkg::cmd_t   head_o
);

  u2ncr_pkg::cmd_t mem_q [u2ncr_pkg::CQ_DEPTH];
  logic [u2ncr_pkg::CQ_PTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [u2ncr_pkg::CQ_PTR_W:0]   fill_q, fill_d;
  logic do_push, do_pop;

  assign full_o  = fill_q == (u2ncr_pkg::CQ_PTR_W+1)'(u2ncr_pkg::CQ_DEPTH);
  assign empty_o = fill_q == '0;
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointer and fill update
  always_comb begin
    wr_d   = do_push ? wr_q + 1'b1 : wr_q;
    rd_d   = do_pop ? rd_q + 1'b1 : rd_q;
    fill_d = fill_q;
    if (do_push && !do_pop) begin
      fill_d = fill_q + 1'b1;
    end else if (!do_push && do_pop) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

endmodule

// ===== rtl/core/u2ncr_back.sv =====
// ----------------------------------------------------------------------------
// u2ncr_back
// executes commands: raw bytes, decimal references and text terminators
// ----------------------------------------------------------------------------
`include "utf8_to_numeric_char_ref_defines.svh"

module u2ncr_back #(
  parameter int OUT_LIMIT = u2ncr_pkg::OUT_LIMIT_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  u2ncr_pkg::cmd_t   head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              byte_valid_o,
  output logic              run_last_o
);

  localparam int CntW = $clog2(OUT_LIMIT + 1);
  localparam int SumW = CntW + 1;
  localparam int ProdW = u2ncr_pkg::CODE_W + 20;

  u2ncr_pkg::back_state_e state_q, state_d;
  logic [CntW-1:0]                 cnt_q, cnt_d;
  logic                            stop_q, stop_d;
  logic [u2ncr_pkg::CODE_W-1:0]    val_q, val_d;
  logic [u2ncr_pkg::ND_W-1:0]      nd_q, nd_d, idx_q, idx_d;
  logic                            end_q, end_d;
  logic [3:0]                      dig_q [u2ncr_pkg::MAX_DIGITS];
  logic                            dig_we;
  logic                            ovalid_q;
  logic [7:0]                      obyte_q;
  logic                            obv_q, olast_q;
  logic                            load;
  logic [7:0]                      ld_byte;
  logic                            ld_bv, ld_last;
  logic                            slot;
  logic [ProdW-1:0]                prod;
  logic [u2ncr_pkg::CODE_W-1:0]    quo;
  logic [u2ncr_pkg::CODE_W-1:0]    quo10;
  logic [3:0]                      rem;
  logic                            fits;
  logic                            raw_hits_cap;

  assign slot = !ovalid_q || out_ready_i;

  // one decimal digit per cycle through the reciprocal multiply
  assign prod  = val_q * u2ncr_pkg::RECIP10;
  assign quo   = u2ncr_pkg::CODE_W'(prod[ProdW-1:u2ncr_pkg::RECIP_SHR]);
  assign quo10 = (quo << 3) + (quo << 1);
  assign rem   = 4'(val_q - quo10);

  assign fits = (SumW'(cnt_q) + SumW'(nd_q) + SumW'(u2ncr_pkg::REF_EXTRA))
                < SumW'(OUT_LIMIT);
  assign raw_hits_cap = (SumW'(cnt_q) + SumW'(1)) >= SumW'(OUT_LIMIT);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      u2ncr_pkg::BK_IDLE: begin
        if (!empty_i && head_i.kind == u2ncr_pkg::CMD_REF && !stop_q) begin
          state_d = u2ncr_pkg::BK_CONV;
        end
      end
      u2ncr_pkg::BK_CONV: begin
        if (quo == '0) begin
          state_d = u2ncr_pkg::BK_CHECK;
        end
      end
      u2ncr_pkg::BK_CHECK: state_d = fits ? u2ncr_pkg::BK_AMP : u2ncr_pkg::BK_IDLE;
      u2ncr_pkg::BK_AMP: begin
        if (slot) begin
          state_d = u2ncr_pkg::BK_HASH;
        end
      end
      u2ncr_pkg::BK_HASH: begin
        if (slot) begin
          state_d = u2ncr_pkg::BK_DIG;
        end
      end
      u2ncr_pkg::BK_DIG: begin
        if (slot && idx_q == '0) begin
          state_d = u2ncr_pkg::BK_SEMI;
        end
      end
      u2ncr_pkg::BK_SEMI: begin
        if (slot) begin
          state_d = u2ncr_pkg::BK_IDLE;
        end
      end
      default: state_d = u2ncr_pkg::BK_IDLE;
    endcase
  end

  // datapath and output loads
  always_comb begin
    pop_o   = 1'b0;
    load    = 1'b0;
    ld_byte = 8'd0;
    ld_bv   = 1'b1;
    ld_last = 1'b0;
    cnt_d   = cnt_q;
    stop_d  = stop_q;
    val_d   = val_q;
    nd_d    = nd_q;
    idx_d   = idx_q;
    end_d   = end_q;
    dig_we  = 1'b0;
    case (state_q)
      u2ncr_pkg::BK_IDLE: begin
        if (!empty_i) begin
          case (head_i.kind)
            u2ncr_pkg::CMD_REF: begin
              pop_o = 1'b1;
              val_d = head_i.data;
              nd_d  = '0;
              end_d = head_i.item_end;
            end
            u2ncr_pkg::CMD_RAW: begin
              if (stop_q) begin
                pop_o = 1'b1;
              end else if (slot) begin
                pop_o   = 1'b1;
                load    = 1'b1;
                ld_byte = head_i.data[7:0];
                ld_last = head_i.item_end;
                cnt_d   = cnt_q + CntW'(1);
                stop_d  = raw_hits_cap;
              end
            end
            u2ncr_pkg::CMD_TERM: begin
              if (slot) begin
                pop_o   = 1'b1;
                load    = 1'b1;
                ld_bv   = 1'b0;
                ld_last = 1'b1;
                cnt_d   = '0;
                stop_d  = 1'b0;
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      u2ncr_pkg::BK_CONV: begin
        dig_we = 1'b1;
        val_d  = quo;
        nd_d   = nd_q + 1'b1;
      end
      // reference that would not fit ends the output of this text
      u2ncr_pkg::BK_CHECK: begin
        if (fits) begin
          cnt_d = cnt_q + CntW'(nd_q) + CntW'(u2ncr_pkg::REF_EXTRA);
          idx_d = nd_q - 1'b1;
        end else begin
          stop_d = 1'b1;
        end
      end
      u2ncr_pkg::BK_AMP: begin
        load    = slot;
        ld_byte = u2ncr_pkg::CH_AMP;
      end
      u2ncr_pkg::BK_HASH: begin
        load    = slot;
        ld_byte = u2ncr_pkg::CH_HASH;
      end
      u2ncr_pkg::BK_DIG: begin
        load    = slot;
        ld_byte = u2ncr_pkg::CH_ZERO + {4'd0, dig_q[idx_q]};
        if (slot && idx_q != '0) begin
          idx_d = idx_q - 1'b1;
        end
      end
      u2ncr_pkg::BK_SEMI: begin
        load    = slot;
        ld_byte = u2ncr_pkg::CH_SEMI;
        ld_last = end_q;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= u2ncr_pkg::BK_IDLE;
      cnt_q    <= '0;
      stop_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      stop_q   <= stop_d;
      ovalid_q <= load || (ovalid_q && !out_ready_i);
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    nd_q  <= nd_d;
    idx_q <= idx_d;
    end_q <= end_d;
    if (dig_we) begin
      dig_q[nd_q] <= rem;
    end
    if (load) begin
      obyte_q <= ld_byte;
      obv_q   <= ld_bv;
      olast_q <= ld_last;
    end
  end

  assign out_valid_o  = ovalid_q;
  assign out_byte_o   = obyte_q;
  assign byte_valid_o = obv_q;
  assign run_last_o   = olast_q;

  // checks
  `U2NCR_ASSERT_NOW(a_cnt_cap, 1'b1, SumW'(cnt_q) <= SumW'(OUT_LIMIT), "output count above cap")
  `U2NCR_ASSERT_NEXT(a_term_clear, pop_o && head_i.kind == u2ncr_pkg::CMD_TERM, cnt_q == '0 && !stop_q, "terminator did not clear count")
  `U2NCR_ASSERT_NOW(a_no_byte_stopped, load && ld_bv && state_q == u2ncr_pkg::BK_IDLE, !stop_q, "byte emitted after output stopped")
  `U2NCR_ASSERT_NOW(a_digits_known, state_q == u2ncr_pkg::BK_AMP || state_q == u2ncr_pkg::BK_DIG, nd_q != '0, "reference without digits")

endmodule

// ===== rtl/core/utf8_to_numeric_char_ref.sv =====
// ----------------------------------------------------------------------------
// utf8_to_numeric_char_ref
// utf8 text to text with decimal character references for multi-byte codes
// ----------------------------------------------------------------------------
// usage:
//   s_axis carries one input byte per word, tlast on the final byte of a text.
//   m_axis carries one output byte per word; tuser is 1 for a real byte and 0
//   for the terminator word that closes each text; tlast marks the last word
//   caused by one input word.
//   a plain byte goes combinationally through the front end into the command
//   queue and is registered in the output word when the back end takes it:
//   about one word a cycle while m_axis_tready stays high. a multi-byte code
//   of N decimal digits costs the back end a divide by ten per digit, one
//   length check and N+3 bytes out; this divide loop sets the rate for
//   non-ascii text. the end of a text inside a sequence adds flush states.
//   reset clears pending-sequence and cap-count state; no clearing pass needed.
//   when m_axis_tready is low the output word holds, the back end stops, the
//   command queue fills and s_axis_tready then drops.
// ----------------------------------------------------------------------------
module utf8_to_numeric_char_ref #(
  parameter int OUT_LIMIT = u2ncr_pkg::OUT_LIMIT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // text_last
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic       m_axis_tuser,   // [0] byte_valid
  output logic       m_axis_tlast    // run_last
);

  logic            push;
  u2ncr_pkg::cmd_t push_cmd;
  logic            q_full;
  logic            q_empty;
  logic            pop;
  u2ncr_pkg::cmd_t head;

  // byte intake and sequence tracking
  u2ncr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_byte_i   (s_axis_tdata),
    .text_last_i (s_axis_tlast),
    .push_o      (push),
    .push_cmd_o  (push_cmd),
    .q_full_i    (q_full)
  );

  // command queue
  u2ncr_cmdq u_cmdq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .full_o     (q_full),
    .pop_i      (pop),
    .empty_o    (q_empty),
    .head_o     (head)
  );

  // output generation
  u2ncr_back #(
    .OUT_LIMIT (OUT_LIMIT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .empty_i      (q_empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_byte_o   (m_axis_tdata),
    .byte_valid_o (m_axis_tuser),
    .run_last_o   (m_axis_tlast)
  );

endmodule

// ===== verif/u2ncr_stream_checker.sv =====
// ----------------------------------------------------------------------------
// u2ncr_stream_checker
// watches both streams of the utf8 to numeric reference converter, predicts
// every output word from the accepted input words and compares in order
// ----------------------------------------------------------------------------
module u2ncr_stream_checker #(
  parameter int OUT_LIMIT = u2ncr_pkg::OUT_LIMIT_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid,
  input  logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
  input  logic       s_axis_tlast,   // text_last
  input  logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  input  logic [7:0] m_axis_tdata,   // [7:0] out_byte
  input  logic       m_axis_tuser,   // [0] byte_valid
  input  logic       m_axis_tlast,   // run_last
  output int         err_cnt_o,
  output int         pend_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       real_byte;
    logic       item_end;
  } out_word_t;

  // words still owed by the block, and words caused by the current input
  out_word_t exp_words[$];
  out_word_t item_words[$];

  // converter state as seen from outside
  logic [7:0] held_b [3];
  int         held_n;
  logic [7:0] lead_b;
  logic       lead_wait;
  int         out_n;
  logic       out_stop;

  // continuation bytes a lead byte asks for
  function automatic int follow_cnt(input logic [7:0] b);
    if (b[7:3] == 5'b11110) return 3;
    if (b[7:4] == 4'b1110) return 2;
    if (b[7:5] == 3'b110) return 1;
    return 0;
  endfunction

  // code point of a lead and its continuation bytes
  function automatic logic [20:0] code_point(input logic [7:0] lead,
                                             input logic [7:0] c0,
                                             input logic [7:0] c1,
                                             input logic [7:0] c2,
                                             input int k);
    case (k)
      3:       return {lead[2:0], c0[5:0], c1[5:0], c2[5:0]};
      2:       return {5'd0, lead[3:0], c0[5:0], c1[5:0]};
      default: return {10'd0, lead[4:0], c0[5:0]};
    endcase
  endfunction

  task automatic clear_state();
    held_b    = '{default: 8'h00};
    held_n    = 0;
    lead_b    = 8'h00;
    lead_wait = 1'b0;
    out_n     = 0;
    out_stop  = 1'b0;
  endtask

  task automatic note_error(input string msg);
    $display("%0t: %s", $time, msg);
    err_cnt_o++;
  endtask

  task automatic put_word(input logic [7:0] ch, input logic real_byte);
    out_word_t w;
    w.ch        = ch;
    w.real_byte = real_byte;
    w.item_end  = 1'b0;
    item_words.push_back(w);
  endtask

  // raw byte, counted against the output cap
  task automatic put_raw(input logic [7:0] b);
    if (!out_stop) begin
      put_word(b, 1'b1);
      out_n++;
      if (out_n >= OUT_LIMIT) out_stop = 1'b1;
    end
  endtask

  // decimal reference, dropped whole when it would not fit below the cap
  task automatic put_ref(input logic [20:0] cp);
    logic [7:0] dig [$];
    int         v;
    v = cp;
    if (out_stop) return;
    do begin
      dig.push_front(u2ncr_pkg::CH_ZERO + 8'(v % 10));
      v = v / 10;
    end while (v != 0);
    if (out_n + dig.size() + 3 < OUT_LIMIT) begin
      put_word(u2ncr_pkg::CH_AMP, 1'b1);
      put_word(u2ncr_pkg::CH_HASH, 1'b1);
      foreach (dig[d]) put_word(dig[d], 1'b1);
      put_word(u2ncr_pkg::CH_SEMI, 1'b1);
      out_n += dig.size() + 3;
    end else begin
      out_stop = 1'b1;
    end
  endtask

  // expected words for one accepted input byte
  task automatic convert_byte(input logic [7:0] b, input logic last);
    logic [7:0] seq_b [7];
    out_word_t  w;
    int         seq_n;
    int         i;
    int         k;
    item_words.delete();
    if (lead_wait) begin
      if (held_n < 3) begin
        held_b[held_n] = b;
        held_n++;
      end
      if (held_n >= follow_cnt(lead_b)) begin
        put_ref(code_point(lead_b, held_b[0], held_b[1], held_b[2], follow_cnt(lead_b)));
        lead_wait = 1'b0;
        held_n    = 0;
      end
    end else if (follow_cnt(b) != 0) begin
      lead_b    = b;
      lead_wait = 1'b1;
      held_n    = 0;
    end else begin
      put_raw(b);
    end

    // end of text: unfinished sequence goes out raw, held bytes rescanned
    if (last) begin
      if (lead_wait) begin
        seq_b    = '{default: 8'h00};
        seq_b[0] = lead_b;
        seq_n    = 1;
        for (k = 0; k < held_n; k++) begin
          seq_b[seq_n] = held_b[k];
          seq_n++;
        end
        i = 0;
        while (i < seq_n) begin
          k = follow_cnt(seq_b[i]);
          if (k != 0 && i + k < seq_n) begin
            put_ref(code_point(seq_b[i], seq_b[i+1], seq_b[i+2], seq_b[i+3], k));
            i += k + 1;
          end else begin
            put_raw(seq_b[i]);
            i++;
          end
        end
      end
      put_word(8'h00, 1'b0);
      clear_state();
    end

    if (item_words.size() > 0) begin
      w = item_words.pop_back();
      w.item_end = 1'b1;
      item_words.push_back(w);
    end
    foreach (item_words[j]) exp_words.push_back(item_words[j]);
  endtask

  // compare one output word with the oldest expected word
  task automatic check_word();
    out_word_t w;
    if (exp_words.size() == 0) begin
      note_error($sformatf("unexpected word: expected none, actual tdata=%02h tuser=%0b tlast=%0b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast));
      return;
    end
    w = exp_words.pop_front();
    if (m_axis_tdata !== w.ch)
      note_error($sformatf("out_byte: expected %02h, actual %02h", w.ch, m_axis_tdata));
    if (m_axis_tuser !== w.real_byte)
      note_error($sformatf("byte_valid: expected %0b, actual %0b", w.real_byte, m_axis_tuser));
    if (m_axis_tlast !== w.item_end)
      note_error($sformatf("run_last: expected %0b, actual %0b", w.item_end, m_axis_tlast));
  endtask

  // sample both handshakes at each rising edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_state();
      exp_words.delete();
      err_cnt_o  = 0;
      pend_cnt_o = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) convert_byte(s_axis_tdata, s_axis_tlast);
      if (m_axis_tvalid && m_axis_tready) check_word();
      pend_cnt_o = exp_words.size();
    end
  end

endmodule

// ===== verif/tb_utf8_to_numeric_char_ref.sv =====
// ----------------------------------------------------------------------------
// tb_utf8_to_numeric_char_ref
// drives texts into the utf8 to numeric reference converter: a directed set
// of edge bytes and sequences, a text that runs into the output cap, and random
// texts of well-formed and broken sequences, with random gaps on both sides
// ----------------------------------------------------------------------------
module tb_utf8_to_numeric_char_ref;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;   // [7:0] in_byte
  logic       s_axis_tlast  = 1'b0;    // text_last
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;            // [7:0] out_byte
  logic       m_axis_tuser;            // [0] byte_valid
  logic       m_axis_tlast;            // run_last

  int         err_cnt;
  int         pend_cnt;
  int         rx_hold      = 0;
  int         rx_calm_left = 0;
  bit         calm_text    = 1'b0;
  logic [7:0] text_bytes [$];

  utf8_to_numeric_char_ref dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  u2ncr_stream_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .err_cnt_o     (err_cnt),
    .pend_cnt_o    (pend_cnt)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // hard stop
  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // idle length: mostly none or short, now and then long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // receiver: random stalls, with calm stretches of full speed
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold       <= rx_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (rx_calm_left > 0) begin
        rx_calm_left <= rx_calm_left - 1;
      end else if ($urandom_range(0, 299) == 0) begin
        rx_calm_left <= $urandom_range(50, 200);
      end else begin
        rx_hold <= idle_len();
      end
    end
  end

  // continuation byte, sometimes a stray byte instead
  function automatic logic [7:0] tail_byte();
    if ($urandom_range(0, 9) == 0) return 8'($urandom);
    return {2'b10, 6'($urandom)};
  endfunction

  task automatic add_seq(input int n_follow, input logic [7:0] lead);
    text_bytes.push_back(lead);
    repeat (n_follow) text_bytes.push_back(tail_byte());
  endtask

  // one random piece: ascii, a 2/3/4-byte sequence or a noise byte
  task automatic add_piece();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      text_bytes.push_back({1'b0, 7'($urandom)});
    end else if (r < 50) begin
      add_seq(1, {3'b110, 5'($urandom)});
    end else if (r < 70) begin
      add_seq(2, {4'b1110, 4'($urandom)});
    end else if (r < 90) begin
      add_seq(3, {5'b11110, 3'($urandom)});
    end else begin
      text_bytes.push_back(8'($urandom));
    end
  endtask

  // one word on the input stream, after an optional gap
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = calm_text ? 0 : idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic send_text();
    calm_text = ($urandom_range(0, 4) == 0);
    foreach (text_bytes[i]) send_byte(text_bytes[i], i == text_bytes.size() - 1);
    text_bytes.delete();
  endtask

  // seven-digit references up to the cap, then a reference near the boundary
  task automatic build_cap_text();
    repeat (24) add_seq(3, {6'b111101, 2'($urandom)});
    repeat ($urandom_range(3, 8)) text_bytes.push_back({1'b0, 7'($urandom)});
    add_seq(3, {6'b111101, 2'($urandom)});
    repeat ($urandom_range(1, 4)) add_piece();
  endtask

  // short text, cut at a random length so it may end inside a sequence
  task automatic build_short_text();
    int len;
    len = $urandom_range(1, 16);
    while (text_bytes.size() < len) add_piece();
    while (text_bytes.size() > len) void'(text_bytes.pop_back());
  endtask

  initial begin
    int sent;
    int guard;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // zero byte, ascii top, raw high bytes, smallest and largest 2-byte codes
    text_bytes = '{8'h00, 8'h7f, 8'h80, 8'hff, 8'hf8, 8'hc2, 8'h80, 8'hdf, 8'hbf};
    send_text();
    // single-digit code, largest 4-byte code, text ending inside a sequence
    text_bytes = '{8'he0, 8'h80, 8'h80, 8'hf7, 8'hbf, 8'hbf, 8'hbf, 8'hf0, 8'hc3, 8'ha9};
    send_text();
    // lone lead byte as the whole text
    text_bytes = '{8'he2};
    send_text();
    // unfinished 3-byte sequence falls back to raw bytes
    text_bytes = '{8'h41, 8'he2, 8'h82};
    send_text();

    // random part: one capped text, then short texts
    sent = 0;
    build_cap_text();
    send_text();
    while (sent < 40) begin
      build_short_text();
      sent += text_bytes.size();
      send_text();
    end
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);

    // drain, then let the block settle
    guard = 0;
    while (pend_cnt != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (50) @(posedge clk_i);

    if (err_cnt == 0 && pend_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
